@@ src/thermal_power_derating_core_macros.svh @@
// assertion macros shared by the derating core files
`ifndef THERMAL_POWER_DERATING_CORE_MACROS_SVH
`define THERMAL_POWER_DERATING_CORE_MACROS_SVH

`ifndef SYNTHESIS
// checked property, held off while reset is low
`define TPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, evaluated at every edge including reset
`define TPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPD_ASSERT(label, prop, msg)
`define TPD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ src/tpd_pkg.sv @@
`timescale 1ns / 1ps

package tpd_pkg;

    // field widths
    localparam int TEMP_W     = 13;
    localparam int FRAC_BITS  = 15;
    localparam int HYST_W     = 10;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int MAG_W      = TEMP_W;
    localparam int DIFF_W     = ((TEMP_W > HYST_W) ? TEMP_W : HYST_W) + 2;
    localparam int NUM_W      = FRAC_W + MAG_W;
    localparam int QUO_W      = FRAC_W;
    localparam int CNT_W      = $clog2(QUO_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (FRAC_W > TEMP_W) ? FRAC_W : TEMP_W;
    localparam int ZONE_N     = 3;

    // zone flag positions
    localparam int ZONE_SW  = 0;
    localparam int ZONE_MAG = 1;
    localparam int ZONE_AMB = 2;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic signed [DIFF_W-1:0] dtemp_t;
    typedef logic [HYST_W-1:0]        hyst_t;
    typedef logic [FRAC_W-1:0]        frac_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [ZONE_N-1:0]        zones_t;

    localparam frac_t FRAC_ONE = frac_t'(1 << FRAC_BITS);

    // register reset values
    localparam temp_t SIC_FULL_RST   = temp_t'(1600);
    localparam temp_t SIC_ZERO_RST   = temp_t'(1840);
    localparam temp_t MAG_FULL_RST   = temp_t'(1920);
    localparam temp_t MAG_ZERO_RST   = temp_t'(2240);
    localparam temp_t AMB_FULL_RST   = temp_t'(880);
    localparam temp_t AMB_FLOOR_RST  = temp_t'(1120);
    localparam hyst_t HYST_RST       = hyst_t'(80);
    localparam frac_t FLOOR_FRAC_RST = frac_t'(16384);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIC_FULL,
        REG_SIC_ZERO,
        REG_MAG_FULL,
        REG_MAG_ZERO,
        REG_AMB_FULL,
        REG_AMB_FLOOR,
        REG_HYST,
        REG_FLOOR_FRAC
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LANE_IDLE,
        LANE_MUL,
        LANE_DIV,
        LANE_DONE
    } lane_state_t;

    // control from the core to each lane
    typedef struct packed {
        logic start;
        logic ack;
    } lane_ctl_t;

    // status from each lane to the merge stage
    typedef struct packed {
        logic  done;
        logic  active;
        frac_t frac;
    } lane_stat_t;

endpackage

@@ src/tpd_in_if.sv @@
`timescale 1ns / 1ps

interface tpd_in_if;
    import tpd_pkg::*;

    logic  valid;
    logic  ready;
    temp_t temp_switch_a;
    temp_t temp_switch_b;
    temp_t temp_magnetics;
    temp_t temp_ambient;

    modport source (
        output valid,
        output temp_switch_a,
        output temp_switch_b,
        output temp_magnetics,
        output temp_ambient,
        input  ready
    );

    modport sink (
        input  valid,
        input  temp_switch_a,
        input  temp_switch_b,
        input  temp_magnetics,
        input  temp_ambient,
        output ready
    );
endinterface

@@ src/tpd_out_if.sv @@
`timescale 1ns / 1ps

interface tpd_out_if;
    import tpd_pkg::*;

    logic   valid;
    logic   ready;
    frac_t  power_limit;
    zones_t zones_derating;

    modport source (
        output valid,
        output power_limit,
        output zones_derating,
        input  ready
    );

    modport sink (
        input  valid,
        input  power_limit,
        input  zones_derating,
        output ready
    );
endinterface

@@ src/tpd_lane.sv @@
`timescale 1ns / 1ps
`include "thermal_power_derating_core_macros.svh"

module tpd_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  tpd_pkg::lane_ctl_t ctl,
    input  logic               floor_mode,
    input  tpd_pkg::temp_t     temp,
    input  tpd_pkg::temp_t     full_temp,
    input  tpd_pkg::temp_t     end_temp,
    input  tpd_pkg::hyst_t     hyst,
    input  tpd_pkg::frac_t     floor_frac,
    output tpd_pkg::lane_stat_t stat
);
    import tpd_pkg::*;

    lane_state_t state_reg, state_next;
    logic        flag_reg, flag_next;
    logic        fixed_reg, fixed_next;
    frac_t       fixval_reg, fixval_next;
    mag_t        opa_reg, opa_next;
    frac_t       span_reg, span_next;
    mag_t        den_reg, den_next;
    mag_t        rem_reg, rem_next;
    logic [QUO_W-1:0] low_reg, low_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    dtemp_t t_x, full_x, end_x, hyst_x, exit_thr;
    dtemp_t diff_end, diff_full, den_x;
    frac_t  floor_sat;
    logic   active_now, fix_now;
    frac_t  fixval_now;
    mag_t   opa_now, den_now;

    logic [NUM_W-1:0] prod, shift_num, num;
    logic [MAG_W:0]   shifted, den_ext, trial;
    logic             ge;
    mag_t             rem_step;

    // widened operands
    assign t_x      = dtemp_t'(temp);
    assign full_x   = dtemp_t'(full_temp);
    assign end_x    = dtemp_t'(end_temp);
    assign hyst_x   = {{(DIFF_W - HYST_W){1'b0}}, hyst};
    assign exit_thr = full_x - hyst_x;
    assign diff_end = end_x - t_x;
    assign diff_full = t_x - full_x;
    assign den_x    = end_x - full_x;
    assign floor_sat = (floor_frac > FRAC_ONE) ? FRAC_ONE : floor_frac;

    // zone flag with hysteresis, and the segment this temperature falls in
    always_comb
    begin
        active_now = flag_reg ? !(t_x <= exit_thr) : (t_x > full_x);
        fix_now    = 1'b1;
        fixval_now = FRAC_ONE;
        opa_now    = diff_end[MAG_W-1:0];
        den_now    = den_x[MAG_W-1:0];
        if (active_now)
        begin
            if (!floor_mode)
            begin
                if (diff_end <= 0)
                begin
                    fixval_now = '0;
                end
                else if (den_x > 0 && diff_end < den_x)
                begin
                    fix_now = 1'b0;
                end
            end
            else
            begin
                opa_now = diff_full[MAG_W-1:0];
                if (diff_end <= 0)
                begin
                    fixval_now = floor_sat;
                end
                else if (diff_full > 0)
                begin
                    fix_now = 1'b0;
                end
            end
        end
    end

    // dividend: slope product for the floor segment, scaled offset otherwise
    assign prod      = NUM_W'(span_reg) * NUM_W'(opa_reg);
    assign shift_num = NUM_W'({opa_reg, {FRAC_BITS{1'b0}}});
    assign num       = floor_mode ? prod : shift_num;

    // one restoring division step
    assign shifted  = {rem_reg, low_reg[QUO_W-1]};
    assign den_ext  = {1'b0, den_reg};
    assign ge       = (shifted >= den_ext);
    assign trial    = shifted - den_ext;
    assign rem_step = ge ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];

    // lane sequencer
    always_comb
    begin
        state_next  = state_reg;
        flag_next   = flag_reg;
        fixed_next  = fixed_reg;
        fixval_next = fixval_reg;
        opa_next    = opa_reg;
        span_next   = span_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        low_next    = low_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        unique case (state_reg)
            LANE_IDLE:
            begin
                if (ctl.start)
                begin
                    flag_next   = active_now;
                    fixed_next  = fix_now;
                    fixval_next = fixval_now;
                    opa_next    = opa_now;
                    span_next   = FRAC_ONE - floor_sat;
                    den_next    = den_now;
                    state_next  = LANE_MUL;
                end
            end
            LANE_MUL:
            begin
                rem_next   = num[NUM_W-1:QUO_W];
                low_next   = num[QUO_W-1:0];
                quo_next   = '0;
                cnt_next   = CNT_W'(QUO_W - 1);
                state_next = LANE_DIV;
            end
            LANE_DIV:
            begin
                rem_next = rem_step;
                low_next = {low_reg[QUO_W-2:0], 1'b0};
                quo_next = {quo_reg[QUO_W-2:0], ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = LANE_DONE;
                end
            end
            LANE_DONE:
            begin
                if (ctl.ack)
                begin
                    state_next = LANE_IDLE;
                end
            end
            default:
            begin
                state_next = LANE_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LANE_IDLE;
            flag_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            flag_reg  <= flag_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        fixed_reg  <= fixed_next;
        fixval_reg <= fixval_next;
        opa_reg    <= opa_next;
        span_reg   <= span_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        low_reg    <= low_next;
        quo_reg    <= quo_next;
    end

    // lane result
    assign stat.done   = (state_reg == LANE_DONE);
    assign stat.active = flag_reg;
    assign stat.frac   = fixed_reg  ? fixval_reg :
                         floor_mode ? (FRAC_ONE - quo_reg) : quo_reg;

    `TPD_ASSERT(a_lane_rem_below_den, (state_reg == LANE_DIV && !fixed_reg) |-> (rem_reg < den_reg), "lane remainder not below divisor")
    `TPD_ASSERT(a_lane_flag_hold, !ctl.start |=> $stable(flag_reg), "zone flag moved without an item")
    `TPD_ASSERT(a_lane_frac_range, stat.done |-> (stat.frac <= FRAC_ONE), "lane fraction above full power")
endmodule

@@ src/tpd_merge.sv @@
`timescale 1ns / 1ps

module tpd_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  tpd_pkg::lane_stat_t sw_stat,
    input  tpd_pkg::lane_stat_t mag_stat,
    input  tpd_pkg::lane_stat_t amb_stat,
    input  logic                out_ready,
    output logic                out_valid,
    output tpd_pkg::frac_t      power_limit,
    output tpd_pkg::zones_t     zones,
    output logic                load
);
    import tpd_pkg::*;

    logic   valid_reg, valid_next;
    frac_t  limit_reg;
    zones_t zones_reg;
    frac_t  min_a, min_b;
    zones_t zones_now;

    // lowest fraction of the three zones
    assign min_a = (mag_stat.frac < sw_stat.frac) ? mag_stat.frac : sw_stat.frac;
    assign min_b = (amb_stat.frac < min_a) ? amb_stat.frac : min_a;

    always_comb
    begin
        zones_now           = '0;
        zones_now[ZONE_SW]  = sw_stat.active;
        zones_now[ZONE_MAG] = mag_stat.active;
        zones_now[ZONE_AMB] = amb_stat.active;
    end

    // output register loads once every lane is done and the slot is free
    assign load       = sw_stat.done && mag_stat.done && amb_stat.done &&
                        (!valid_reg || out_ready);
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            limit_reg <= min_b;
            zones_reg <= zones_now;
        end
    end

    assign out_valid   = valid_reg;
    assign power_limit = limit_reg;
    assign zones       = zones_reg;
endmodule

@@ src/thermal_power_derating_core.sv @@
`timescale 1ns / 1ps
`include "thermal_power_derating_core_macros.svh"

// Thermal power derating: each item carries two switch temperatures, a magnetics
// temperature and an ambient temperature (signed, 1/16 degC) and yields one
// power limit in Q1.15 (32768 is full power) together with the three zone active
// flags. Three lanes, one per zone, update their hysteresis flag, multiply the
// ambient slope and run a restoring divider one quotient bit per cycle; a merge
// stage takes the minimum into the output register. Each lane steps an item
// through MUL, the 16-step divider and DONE, and the result becomes valid
// once the merge stage has loaded it. A finished result waits in the output
// register, and a further item is taken once that register has been loaded.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the core is idle, which the core does not enforce.
module thermal_power_derating_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [tpd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tpd_pkg::CFG_DATA_W-1:0]         cfg_data,
    tpd_in_if.sink                                 in_ch,
    tpd_out_if.source                              out_ch
);
    import tpd_pkg::*;

    temp_t sic_full_reg, sic_zero_reg, mag_full_reg, mag_zero_reg;
    temp_t amb_full_reg, amb_floor_reg;
    hyst_t hyst_reg;
    frac_t floor_frac_reg;

    logic       busy_reg, busy_next;
    logic       start, load;
    lane_ctl_t  ctl;
    lane_stat_t sw_stat, mag_stat, amb_stat;
    temp_t      temp_sw;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sic_full_reg   <= SIC_FULL_RST;
            sic_zero_reg   <= SIC_ZERO_RST;
            mag_full_reg   <= MAG_FULL_RST;
            mag_zero_reg   <= MAG_ZERO_RST;
            amb_full_reg   <= AMB_FULL_RST;
            amb_floor_reg  <= AMB_FLOOR_RST;
            hyst_reg       <= HYST_RST;
            floor_frac_reg <= FLOOR_FRAC_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIC_FULL:   sic_full_reg   <= cfg_data[TEMP_W-1:0];
                REG_SIC_ZERO:   sic_zero_reg   <= cfg_data[TEMP_W-1:0];
                REG_MAG_FULL:   mag_full_reg   <= cfg_data[TEMP_W-1:0];
                REG_MAG_ZERO:   mag_zero_reg   <= cfg_data[TEMP_W-1:0];
                REG_AMB_FULL:   amb_full_reg   <= cfg_data[TEMP_W-1:0];
                REG_AMB_FLOOR:  amb_floor_reg  <= cfg_data[TEMP_W-1:0];
                REG_HYST:       hyst_reg       <= cfg_data[HYST_W-1:0];
                REG_FLOOR_FRAC: floor_frac_reg <= cfg_data[FRAC_W-1:0];
                default:        ;
            endcase
        end
    end

    // one item in flight from acceptance until the merge stage loads it
    assign in_ch.ready = !busy_reg;
    assign start       = in_ch.valid && !busy_reg;
    assign busy_next   = start ? 1'b1 : (load ? 1'b0 : busy_reg);
    assign ctl.start   = start;
    assign ctl.ack     = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // hotter of the two switches
    assign temp_sw = (in_ch.temp_switch_b > in_ch.temp_switch_a) ?
                     in_ch.temp_switch_b : in_ch.temp_switch_a;

    tpd_lane u_lane_sw (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .floor_mode (1'b0),
        .temp       (temp_sw),
        .full_temp  (sic_full_reg),
        .end_temp   (sic_zero_reg),
        .hyst       (hyst_reg),
        .floor_frac (floor_frac_reg),
        .stat       (sw_stat)
    );

    tpd_lane u_lane_mag (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .floor_mode (1'b0),
        .temp       (in_ch.temp_magnetics),
        .full_temp  (mag_full_reg),
        .end_temp   (mag_zero_reg),
        .hyst       (hyst_reg),
        .floor_frac (floor_frac_reg),
        .stat       (mag_stat)
    );

    tpd_lane u_lane_amb (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .floor_mode (1'b1),
        .temp       (in_ch.temp_ambient),
        .full_temp  (amb_full_reg),
        .end_temp   (amb_floor_reg),
        .hyst       (hyst_reg),
        .floor_frac (floor_frac_reg),
        .stat       (amb_stat)
    );

    tpd_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .sw_stat     (sw_stat),
        .mag_stat    (mag_stat),
        .amb_stat    (amb_stat),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .power_limit (out_ch.power_limit),
        .zones       (out_ch.zones_derating),
        .load        (load)
    );

    `TPD_ASSERT(a_lanes_lockstep, (sw_stat.done == mag_stat.done) && (mag_stat.done == amb_stat.done), "lanes finished out of step")
    `TPD_ASSERT(a_limit_range, out_ch.valid |-> (out_ch.power_limit <= FRAC_ONE), "power limit above full power")
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import tpd_pkg::*;

    localparam int  CLK_HALF     = 4;
    localparam int  RESET_CYCLES = 11;
    localparam int  CYCLE_LIMIT  = 500000;
    localparam int  LONG_HOLD    = 400;
    localparam int  SETTLE       = 24;
    localparam int  PHASES       = 8;
    localparam int  PHASE_ITEMS  = 92;

    // expected output of one item
    typedef struct packed {
        frac_t  power_limit;
        zones_t zones;
    } derating_t;

    // predicts the derating core and checks its results in order
    class derating_scoreboard;
        temp_t     sic_full   = SIC_FULL_RST;
        temp_t     sic_zero   = SIC_ZERO_RST;
        temp_t     mag_full   = MAG_FULL_RST;
        temp_t     mag_zero   = MAG_ZERO_RST;
        temp_t     amb_full   = AMB_FULL_RST;
        temp_t     amb_floor  = AMB_FLOOR_RST;
        hyst_t     hyst       = HYST_RST;
        frac_t     floor_frac = FLOOR_FRAC_RST;
        zones_t    active     = '0;
        derating_t limit_q[$];
        int        mismatches = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (cfg_reg_t'(idx))
                REG_SIC_FULL:   sic_full   = temp_t'(data[TEMP_W-1:0]);
                REG_SIC_ZERO:   sic_zero   = temp_t'(data[TEMP_W-1:0]);
                REG_MAG_FULL:   mag_full   = temp_t'(data[TEMP_W-1:0]);
                REG_MAG_ZERO:   mag_zero   = temp_t'(data[TEMP_W-1:0]);
                REG_AMB_FULL:   amb_full   = temp_t'(data[TEMP_W-1:0]);
                REG_AMB_FLOOR:  amb_floor  = temp_t'(data[TEMP_W-1:0]);
                REG_HYST:       hyst       = data[HYST_W-1:0];
                REG_FLOOR_FRAC: floor_frac = data[FRAC_W-1:0];
                default:        ;
            endcase
        endfunction

        // hysteresis flag: set above full, clear at or below full minus hysteresis
        function bit zone_step(int pos, int t, int full);
            if (active[pos])
            begin
                if (t <= full - int'(hyst))
                    active[pos] = 1'b0;
            end
            else if (t > full)
            begin
                active[pos] = 1'b1;
            end
            return active[pos];
        endfunction

        function longint ramp_to_zero(int t, int full, int zero);
            longint den;
            longint f;
            if (t >= zero)
                return 0;
            den = longint'(zero) - longint'(full);
            if (den <= 0)
                return longint'(FRAC_ONE);
            f = ((longint'(zero) - longint'(t)) * longint'(FRAC_ONE)) / den;
            return (f > longint'(FRAC_ONE)) ? longint'(FRAC_ONE) : f;
        endfunction

        function longint ramp_to_floor(int t, int full, int ftemp, longint flr);
            longint den;
            if (t >= ftemp)
                return flr;
            if (t <= full)
                return longint'(FRAC_ONE);
            den = longint'(ftemp) - longint'(full);
            return longint'(FRAC_ONE)
                - ((longint'(FRAC_ONE) - flr) * (longint'(t) - longint'(full))) / den;
        endfunction

        // works out the limit for one accepted item
        function void note_sample(temp_t a, temp_t b, temp_t m, temp_t amb);
            int        t_sw;
            longint    flr;
            longint    lim;
            longint    f;
            derating_t exp_res;
            t_sw = (int'(b) > int'(a)) ? int'(b) : int'(a);
            flr  = longint'(floor_frac);
            lim  = longint'(FRAC_ONE);
            if (flr > longint'(FRAC_ONE))
                flr = longint'(FRAC_ONE);
            if (zone_step(ZONE_SW, t_sw, int'(sic_full)))
            begin
                f = ramp_to_zero(t_sw, int'(sic_full), int'(sic_zero));
                if (f < lim)
                    lim = f;
            end
            if (zone_step(ZONE_MAG, int'(m), int'(mag_full)))
            begin
                f = ramp_to_zero(int'(m), int'(mag_full), int'(mag_zero));
                if (f < lim)
                    lim = f;
            end
            if (zone_step(ZONE_AMB, int'(amb), int'(amb_full)))
            begin
                f = ramp_to_floor(int'(amb), int'(amb_full), int'(amb_floor), flr);
                if (f < lim)
                    lim = f;
            end
            exp_res.power_limit = frac_t'(lim);
            exp_res.zones       = active;
            limit_q.push_back(exp_res);
        endfunction

        function void check_result(frac_t pl, zones_t zn);
            derating_t exp_res;
            if (limit_q.size() == 0)
            begin
                $display("%0t: unexpected item, power_limit %0d zones %b", $time, pl, zn);
                mismatches++;
                return;
            end
            exp_res = limit_q.pop_front();
            if (pl !== exp_res.power_limit)
            begin
                $display("%0t: power_limit expected %0d, got %0d",
                         $time, exp_res.power_limit, pl);
                mismatches++;
            end
            if (zn !== exp_res.zones)
            begin
                $display("%0t: zones_derating expected %b, got %b",
                         $time, exp_res.zones, zn);
                mismatches++;
            end
        endfunction

        function int pending();
            return limit_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tpd_in_if  in_ch ();
    tpd_out_if out_ch ();

    derating_scoreboard sb = new;

    // settings currently loaded, used to aim the stimulus
    int  cur_sf   = 1600;
    int  cur_sz   = 1840;
    int  cur_mf   = 1920;
    int  cur_mz   = 2240;
    int  cur_af   = 880;
    int  cur_aflr = 1120;
    int  cur_hyst = 80;

    bit  tx_pace     = 1'b0;
    bit  rx_pace     = 1'b0;
    bit  rx_hold_req = 1'b0;
    int  rx_stall    = 0;
    int  cycles      = 0;

    thermal_power_derating_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // clock
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // observe register writes, results and accepted items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_reg(cfg_index, cfg_data);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.power_limit, out_ch.zones_derating);
            if (in_ch.valid && in_ch.ready)
                sb.note_sample(in_ch.temp_switch_a, in_ch.temp_switch_b,
                               in_ch.temp_magnetics, in_ch.temp_ambient);
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int sel;
        sel = $urandom_range(19);
        if (sel < 10)
            return 0;
        if (sel < 17)
            return $urandom_range(3, 1);
        if (sel < 19)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic int clip_temp(int v);
        if (v < -4096)
            return -4096;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    // temperature aimed at a zone's thresholds, with some noise
    function automatic temp_t pick_temp(int full, int zero);
        int lo;
        int hi;
        lo = clip_temp(((full < zero) ? full : zero) - cur_hyst - 32);
        hi = clip_temp(((full > zero) ? full : zero) + 32);
        case ($urandom_range(9))
            0: return temp_t'($urandom);
            1:
            begin
                case ($urandom_range(3))
                    0: return temp_t'(-4096);
                    1: return temp_t'(4095);
                    2: return temp_t'(-1);
                    default: return temp_t'(0);
                endcase
            end
            2: return temp_t'(int'($urandom_range(5119)) - 1024);
            default: return temp_t'(int'($urandom_range(hi - lo)) + lo);
        endcase
    endfunction

    // receiver: random stalls plus one long hold on request
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_stall    = LONG_HOLD;
            end
            if (rx_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (rx_pace)
                    rx_stall = gap_len();
            end
        end
    end

    task automatic send_temps(input temp_t a, input temp_t b, input temp_t m, input temp_t amb);
        @(negedge clk);
        in_ch.valid          <= 1'b1;
        in_ch.temp_switch_a  <= a;
        in_ch.temp_switch_b  <= b;
        in_ch.temp_magnetics <= m;
        in_ch.temp_ambient   <= amb;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic idle_in(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
    endtask

    // stop offering items until every result is back
    task automatic wait_results_done();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // load all eight registers once the core has gone idle
    task automatic load_settings(input int sf, input int sz, input int mf, input int mz,
                                 input int af, input int aflr, input int hy, input int ff);
        wait_results_done();
        repeat (4) @(negedge clk);
        cfg_write(REG_SIC_FULL,   CFG_DATA_W'(sf));
        cfg_write(REG_SIC_ZERO,   CFG_DATA_W'(sz));
        cfg_write(REG_MAG_FULL,   CFG_DATA_W'(mf));
        cfg_write(REG_MAG_ZERO,   CFG_DATA_W'(mz));
        cfg_write(REG_AMB_FULL,   CFG_DATA_W'(af));
        cfg_write(REG_AMB_FLOOR,  CFG_DATA_W'(aflr));
        cfg_write(REG_HYST,       CFG_DATA_W'(hy));
        cfg_write(REG_FLOOR_FRAC, CFG_DATA_W'(ff));
        cur_sf   = sf;
        cur_sz   = sz;
        cur_mf   = mf;
        cur_mz   = mz;
        cur_af   = af;
        cur_aflr = aflr;
        cur_hyst = hy;
    endtask

    function automatic int rand_reg_temp();
        if ($urandom_range(7) == 0)
            return int'($urandom_range(8191)) - 4096;
        return int'($urandom_range(5119)) - 1024;
    endfunction

    // end point above the threshold mostly, sometimes equal or below
    function automatic int rand_end_temp(int full);
        case ($urandom_range(7))
            0: return rand_reg_temp();
            1: return full;
            default: return clip_temp(full + int'($urandom_range(700, 1)));
        endcase
    endfunction

    task automatic random_settings();
        int sf;
        int mf;
        int af;
        int hy;
        int ff;
        sf = rand_reg_temp();
        mf = rand_reg_temp();
        af = rand_reg_temp();
        case ($urandom_range(7))
            0: hy = 1023;
            1: hy = 0;
            default: hy = $urandom_range(200, 1);
        endcase
        case ($urandom_range(7))
            0: ff = $urandom_range(65535, 32769);
            1: ff = 32768;
            2: ff = 0;
            default: ff = $urandom_range(32767);
        endcase
        load_settings(sf, rand_end_temp(sf), mf, rand_end_temp(mf),
                      af, rand_end_temp(af), hy, ff);
    endtask

    // stimulus
    initial
    begin
        int phase;
        int n;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_SIC_FULL;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.temp_switch_a  = '0;
        in_ch.temp_switch_b  = '0;
        in_ch.temp_magnetics = '0;
        in_ch.temp_ambient   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: thresholds, hysteresis band, end points, min and max
        send_temps(0, 0, 0, 0);
        send_temps(1600, 0, 0, 0);
        send_temps(1601, 1500, 0, 0);
        send_temps(1000, 1700, 0, 0);
        send_temps(1560, 1520, 0, 0);
        send_temps(1520, 1520, 0, 0);
        send_temps(1840, 0, 1921, 0);
        send_temps(4095, 0, 2240, 881);
        send_temps(0, 0, 1900, 1000);
        send_temps(0, 0, 1840, 1120);
        send_temps(0, 0, 0, 4095);
        send_temps(0, 0, 0, 850);
        send_temps(0, 0, 0, 800);
        send_temps(-4096, -4096, -4096, -4096);
        send_temps(4095, -4096, 4095, 4095);
        send_temps(-1, -1, -1, -1);
        send_temps(1700, 1700, 2000, 1000);

        // widest span, zero below threshold, floor above full power, max hysteresis
        load_settings(-4096, 4095, 0, -500, 100, 50, 1023, 65535);
        send_temps(-4095, -4096, 1, 101);
        send_temps(4094, 0, -600, 4095);
        send_temps(-4096, -4096, -1024, -4096);

        // zero equal to threshold, full-span ambient, no hysteresis, zero floor
        load_settings(4094, 4095, -4096, -4096, -4096, 4095, 0, 0);
        send_temps(4095, 4095, -4095, -4095);
        send_temps(4094, 4094, -4096, 0);
        send_temps(0, 4095, 4095, 4095);
        send_temps(0, 0, 0, -4096);

        // random settings and items
        for (phase = 0; phase < PHASES; phase++)
        begin
            random_settings();
            tx_pace = (phase != 1);
            rx_pace = (phase != 1);
            if (phase == 2)
            begin
                // back-to-back items against a stalled receiver
                tx_pace     = 1'b0;
                rx_hold_req = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    wait_results_done();
                send_temps(pick_temp(cur_sf, cur_sz), pick_temp(cur_sf, cur_sz),
                           pick_temp(cur_mf, cur_mz), pick_temp(cur_af, cur_aflr));
                if (tx_pace)
                    idle_in(gap_len());
            end
        end

        wait_results_done();
        repeat (SETTLE) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
